// ===== rtl/fupa_pkg.sv =====
// Package for the fixed unit pool allocator: codes, widths and defaults.
`timescale 1ns / 1ps
package fupa_pkg;

  localparam int DEF_MAX_UNITS = 1024;
  localparam int DEF_MAX_BATCH = 64;
  localparam int DEF_ADDR_BITS = 26;

  localparam int CMD_W   = 2;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 3;
  localparam int FREE_W  = 11;
  localparam int USIZE_W = 16;
  localparam int UCNT_W  = 11;
  localparam int PROD_W  = USIZE_W + UCNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [USIZE_W-1:0] USIZE_RESET = 16'd4096;
  localparam logic [UCNT_W-1:0]  UCNT_RESET  = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT = 2'd1;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INIT_REFUSED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_READY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO_COUNT   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_TOO_FEW      = 3'd4;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE      = 3'd5;
  localparam logic [STAT_W-1:0] STAT_FULL         = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT_CHK,
    S_FILL,
    S_ALLOC
  } state_t;

endpackage

// ===== rtl/fupa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fupa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fupa_ctrl.sv =====
// Command sequencer: free list pointers, init fill sweep, alloc read-out, result registers.
`timescale 1ns / 1ps
module fupa_ctrl import fupa_pkg::*; #(
  parameter int MAX_UNITS = DEF_MAX_UNITS,
  parameter int MAX_BATCH = DEF_MAX_BATCH,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  localparam int PTR_W = $clog2(MAX_UNITS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [COUNT_W-1:0]   in_count,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [USIZE_W-1:0]   pool_unit_bytes,
  input  logic [UCNT_W-1:0]    pool_unit_total,
  output logic                 ram_we,
  output logic [PTR_W-1:0]     ram_waddr,
  output logic [ADDR_BITS-1:0] ram_wdata,
  output logic [PTR_W-1:0]     ram_raddr,
  input  logic [ADDR_BITS-1:0] ram_rdata,
  output logic                 out_valid,
  output logic [STAT_W-1:0]    out_status,
  output logic [ADDR_BITS-1:0] out_unit_address,
  output logic                 out_last,
  output logic [FREE_W-1:0]    out_free_units
);

  localparam int FT_W  = $clog2(MAX_UNITS + 1);
  localparam int CMP_W = (ADDR_BITS + 1 > PROD_W) ? ADDR_BITS + 1 : PROD_W;
  localparam logic [CMP_W-1:0] POOL_LIMIT = CMP_W'(1) << ADDR_BITS;
  localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(MAX_UNITS - 1);

  state_t state_r, state_nxt;

  logic [PTR_W-1:0]     rp_r, rp_nxt;
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [FT_W-1:0]      ftot_r, ftot_nxt;
  logic                 ready_r, ready_nxt;
  logic [PROD_W-1:0]    pool_bytes_r, pool_bytes_nxt;
  logic [PROD_W-1:0]    bytes_r, bytes_nxt;
  logic [USIZE_W-1:0]   usize_r, usize_nxt;
  logic [UCNT_W-1:0]    ucount_r, ucount_nxt;
  logic [PTR_W-1:0]     fill_idx_r, fill_idx_nxt;
  logic [ADDR_BITS-1:0] fill_addr_r, fill_addr_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;

  logic                 ov_r, ov_nxt;
  logic                 oaddr_sel_r, oaddr_sel_nxt;
  logic [STAT_W-1:0]    ostat_r, ostat_nxt;
  logic                 olast_r, olast_nxt;
  logic [FREE_W-1:0]    ofree_r, ofree_nxt;

  logic accept;
  logic init_bad;
  logic fill_done;
  logic alloc_ok;
  logic free_ok;
  logic [STAT_W-1:0] alloc_err;
  logic [STAT_W-1:0] free_err;
  logic [PTR_W-1:0]  rp_inc;
  logic [PTR_W-1:0]  wp_inc;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign rp_inc = (rp_r == LAST_SLOT) ? '0 : rp_r + PTR_W'(1);
  assign wp_inc = (wp_r == LAST_SLOT) ? '0 : wp_r + PTR_W'(1);

  assign init_bad = ready_r || (usize_r == '0) || (ucount_r == '0) ||
                    (32'(ucount_r) > 32'(MAX_UNITS)) ||
                    (CMP_W'(bytes_r) > POOL_LIMIT);

  assign fill_done = (fill_idx_r == PTR_W'(ucount_r - UCNT_W'(1)));

  always_comb begin
    alloc_ok  = 1'b0;
    alloc_err = STAT_OK;
    if (!ready_r) begin
      alloc_err = STAT_NOT_READY;
    end else if (in_count == '0) begin
      alloc_err = STAT_ZERO_COUNT;
    end else if ((32'(in_count) > 32'(ftot_r)) || (32'(in_count) > 32'(MAX_BATCH))) begin
      alloc_err = STAT_TOO_FEW;
    end else begin
      alloc_ok = 1'b1;
    end
  end

  always_comb begin
    free_ok  = 1'b0;
    free_err = STAT_OK;
    if (!ready_r) begin
      free_err = STAT_NOT_READY;
    end else if (CMP_W'(in_address) >= CMP_W'(pool_bytes_r)) begin
      free_err = STAT_OUTSIDE;
    end else if (32'(ftot_r) >= 32'(MAX_UNITS)) begin
      free_err = STAT_FULL;
    end else begin
      free_ok = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_command == CMD_INIT)) begin
          state_nxt = S_INIT_CHK;
        end else if (accept && (in_command == CMD_ALLOC) && alloc_ok) begin
          state_nxt = S_ALLOC;
        end
      end
      S_INIT_CHK: state_nxt = init_bad ? S_IDLE : S_FILL;
      S_FILL:     state_nxt = fill_done ? S_IDLE : S_FILL;
      S_ALLOC:    state_nxt = (rem_r == COUNT_W'(1)) ? S_IDLE : S_ALLOC;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and result registers
  always_comb begin
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    ftot_nxt       = ftot_r;
    ready_nxt      = ready_r;
    pool_bytes_nxt = pool_bytes_r;
    bytes_nxt      = bytes_r;
    usize_nxt      = usize_r;
    ucount_nxt     = ucount_r;
    fill_idx_nxt   = fill_idx_r;
    fill_addr_nxt  = fill_addr_r;
    rem_nxt        = rem_r;
    ov_nxt         = 1'b0;
    oaddr_sel_nxt  = 1'b0;
    ostat_nxt      = ostat_r;
    olast_nxt      = olast_r;
    ofree_nxt      = ofree_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = in_address;
    ram_raddr      = rp_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_INIT: begin
              usize_nxt  = pool_unit_bytes;
              ucount_nxt = pool_unit_total;
              bytes_nxt  = PROD_W'(pool_unit_bytes) * PROD_W'(pool_unit_total);
            end
            CMD_ALLOC: begin
              if (alloc_ok) begin
                rem_nxt = in_count;
              end else begin
                ov_nxt    = 1'b1;
                ostat_nxt = alloc_err;
                olast_nxt = 1'b1;
                ofree_nxt = FREE_W'(ftot_r);
              end
            end
            CMD_FREE: begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              if (free_ok) begin
                ram_we    = 1'b1;
                wp_nxt    = wp_inc;
                ftot_nxt  = ftot_r + FT_W'(1);
                ostat_nxt = STAT_OK;
                ofree_nxt = FREE_W'(ftot_r + FT_W'(1));
              end else begin
                ostat_nxt = free_err;
                ofree_nxt = FREE_W'(ftot_r);
              end
            end
            default: begin
              // unused command: no result
            end
          endcase
        end
      end
      S_INIT_CHK: begin
        if (init_bad) begin
          ov_nxt    = 1'b1;
          ostat_nxt = STAT_INIT_REFUSED;
          olast_nxt = 1'b1;
          ofree_nxt = FREE_W'(ftot_r);
        end else begin
          fill_idx_nxt  = '0;
          fill_addr_nxt = '0;
        end
      end
      S_FILL: begin
        ram_we        = 1'b1;
        ram_waddr     = fill_idx_r;
        ram_wdata     = fill_addr_r;
        fill_idx_nxt  = fill_idx_r + PTR_W'(1);
        fill_addr_nxt = fill_addr_r + ADDR_BITS'(usize_r);
        if (fill_done) begin
          rp_nxt         = '0;
          wp_nxt         = (32'(ucount_r) >= 32'(MAX_UNITS)) ? '0 : PTR_W'(ucount_r);
          ftot_nxt       = FT_W'(ucount_r);
          pool_bytes_nxt = bytes_r;
          ready_nxt      = 1'b1;
          ov_nxt         = 1'b1;
          ostat_nxt      = STAT_OK;
          olast_nxt      = 1'b1;
          ofree_nxt      = FREE_W'(ucount_r);
        end
      end
      S_ALLOC: begin
        // read issued at rp now; data and result registers line up next cycle
        rp_nxt        = rp_inc;
        ftot_nxt      = ftot_r - FT_W'(1);
        rem_nxt       = rem_r - COUNT_W'(1);
        ov_nxt        = 1'b1;
        oaddr_sel_nxt = 1'b1;
        ostat_nxt     = STAT_OK;
        olast_nxt     = (rem_r == COUNT_W'(1));
        ofree_nxt     = FREE_W'(ftot_r - FT_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rp_r         <= '0;
      wp_r         <= '0;
      ftot_r       <= '0;
      ready_r      <= 1'b0;
      pool_bytes_r <= '0;
      rem_r        <= '0;
      fill_idx_r   <= '0;
      ov_r         <= 1'b0;
      oaddr_sel_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      ftot_r       <= ftot_nxt;
      ready_r      <= ready_nxt;
      pool_bytes_r <= pool_bytes_nxt;
      rem_r        <= rem_nxt;
      fill_idx_r   <= fill_idx_nxt;
      ov_r         <= ov_nxt;
      oaddr_sel_r  <= oaddr_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r     <= bytes_nxt;
    usize_r     <= usize_nxt;
    ucount_r    <= ucount_nxt;
    fill_addr_r <= fill_addr_nxt;
    ostat_r     <= ostat_nxt;
    olast_r     <= olast_nxt;
    ofree_r     <= ofree_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = ostat_r;
  assign out_last         = olast_r;
  assign out_free_units   = ofree_r;
  assign out_unit_address = oaddr_sel_r ? ram_rdata : '0;

endmodule

// ===== rtl/fixed_unit_pool_allocator_core.sv =====
// Top level of the fixed unit pool allocator: config registers, sequencer and free list RAM.
`timescale 1ns / 1ps
// Hands out fixed-size units of one pool as byte offsets, from a FIFO free list in a RAM.
// Command channel: an item (in_command, in_count, in_address) is taken when start is high
// and busy is low. Commands: init pool, allocate in_count units, free one unit.
// Result channel: out_valid strobes for one cycle per result with out_status,
// out_unit_address, out_last and out_free_units. There is no back-pressure: every
// result must be taken in the cycle it is shown.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 unit size, 1 unit count) and
// cfg_data; cfg_ready is always high. Values are sampled only when init is accepted.
// Timing:
//   free, failed alloc: result in the cycle after accept, busy never rises, so one
//   such item can be taken every cycle.
//   alloc of n units: busy while the units are read out; n results, one per cycle, behind
//   the state, RAM read and result registers; one free list RAM read per address sets this rate.
//   init: a check state, then a fill sweep writing one RAM entry per cycle; busy
//   throughout, result right after the sweep (refusal after the check).
// Reset: pool not ready, free list empty, config back to 4096 bytes x 1024 units. The
// RAM is not cleared; init writes every entry that can later be read.
module fixed_unit_pool_allocator_core import fupa_pkg::*; #(
  parameter int MAX_UNITS = DEF_MAX_UNITS,
  parameter int MAX_BATCH = DEF_MAX_BATCH,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [COUNT_W-1:0]    in_count,
  input  logic [ADDR_BITS-1:0]  in_address,
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [ADDR_BITS-1:0]  out_unit_address,
  output logic                  out_last,
  output logic [FREE_W-1:0]     out_free_units,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W = $clog2(MAX_UNITS);

  logic [USIZE_W-1:0]   unit_bytes_r;
  logic [UCNT_W-1:0]    unit_total_r;
  logic                 cfg_wr;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [ADDR_BITS-1:0] ram_wdata;
  logic [PTR_W-1:0]     ram_raddr;
  logic [ADDR_BITS-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_bytes_r <= USIZE_RESET;
      unit_total_r <= UCNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_UNIT_SIZE:  unit_bytes_r <= cfg_data;
        REG_UNIT_COUNT: unit_total_r <= cfg_data[UCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fupa_ctrl #(
    .MAX_UNITS (MAX_UNITS),
    .MAX_BATCH (MAX_BATCH),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_count         (in_count),
    .in_address       (in_address),
    .pool_unit_bytes  (unit_bytes_r),
    .pool_unit_total  (unit_total_r),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_unit_address (out_unit_address),
    .out_last         (out_last),
    .out_free_units   (out_free_units)
  );

  fupa_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_UNITS)
  ) u_free_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the fixed unit pool allocator core: directed and random traffic, in-bench pool model.
`timescale 1ns / 1ps
module tb;
  import fupa_pkg::*;

  localparam int AW            = DEF_ADDR_BITS;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 102;
  localparam int COUNT_TOP     = (1 << COUNT_W) - 1;

  localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [AW-1:0]        ADDR_TOP    = {AW{1'b1}};

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [AW-1:0]     unit_address;
    logic              last;
    logic [FREE_W-1:0] free_units;
  } pool_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  start      = 1'b0;
  logic [CMD_W-1:0]      in_command = '0;
  logic [COUNT_W-1:0]    in_count   = '0;
  logic [AW-1:0]         in_address = '0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  busy;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [AW-1:0]         out_unit_address;
  logic                  out_last;
  logic [FREE_W-1:0]     out_free_units;
  logic                  cfg_ready;

  // pool model state
  logic [USIZE_W-1:0] size_reg  = USIZE_RESET;
  logic [UCNT_W-1:0]  count_reg = UCNT_RESET;
  logic [AW-1:0]      pool_ring [DEF_MAX_UNITS];
  int                 take_slot  = 0;
  int                 put_slot   = 0;
  int                 units_free = 0;
  bit                 pool_up    = 1'b0;
  longint             pool_limit = 0;

  pool_result_t pending_results[$];
  pool_result_t head_result;
  logic [AW-1:0] held_units[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit no_gap = 1'b0;

  fixed_unit_pool_allocator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_count         (in_count),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_unit_address (out_unit_address),
    .out_last         (out_last),
    .out_free_units   (out_free_units),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void expect_result(input logic [STAT_W-1:0] status,
                                        input logic [AW-1:0] addr, input logic last);
    pool_result_t r;
    r.status       = status;
    r.unit_address = addr;
    r.last         = last;
    r.free_units   = FREE_W'(units_free);
    pending_results = {pending_results, r};
  endfunction

  // Advances the pool model by one accepted item and queues what it must produce.
  function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [AW-1:0] addr);
    longint bytes;
    bytes = longint'(size_reg) * longint'(count_reg);
    case (cmd)
      CMD_INIT: begin
        if (pool_up || size_reg == 0 || count_reg == 0 || count_reg > DEF_MAX_UNITS ||
            bytes > (longint'(1) << AW)) begin
          expect_result(STAT_INIT_REFUSED, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(count_reg); i++) pool_ring[i] = AW'(i * int'(size_reg));
          take_slot  = 0;
          put_slot   = (count_reg >= DEF_MAX_UNITS) ? 0 : int'(count_reg);
          units_free = int'(count_reg);
          pool_limit = bytes;
          pool_up    = 1'b1;
          expect_result(STAT_OK, '0, 1'b1);
        end
      end
      CMD_ALLOC: begin
        if (!pool_up) begin
          expect_result(STAT_NOT_READY, '0, 1'b1);
        end else if (cnt == 0) begin
          expect_result(STAT_ZERO_COUNT, '0, 1'b1);
        end else if (cnt > units_free || cnt > DEF_MAX_BATCH) begin
          expect_result(STAT_TOO_FEW, '0, 1'b1);
        end else begin
          for (int k = 0; k < int'(cnt); k++) begin
            held_units = {held_units, pool_ring[take_slot]};
            units_free--;
            expect_result(STAT_OK, pool_ring[take_slot], k == int'(cnt) - 1);
            take_slot = (take_slot + 1 >= DEF_MAX_UNITS) ? 0 : take_slot + 1;
          end
        end
      end
      CMD_FREE: begin
        if (!pool_up) begin
          expect_result(STAT_NOT_READY, '0, 1'b1);
        end else if (longint'(addr) >= pool_limit) begin
          expect_result(STAT_OUTSIDE, '0, 1'b1);
        end else if (units_free >= DEF_MAX_UNITS) begin
          expect_result(STAT_FULL, '0, 1'b1);
        end else begin
          pool_ring[put_slot] = addr;
          put_slot = (put_slot + 1 >= DEF_MAX_UNITS) ? 0 : put_slot + 1;
          units_free++;
          expect_result(STAT_OK, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] cnt,
                           input logic [AW-1:0] addr);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_count   <= cnt;
    in_address <= addr;
    do @(posedge clk); while (busy);
    apply_command(cmd, cnt, addr);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_UNIT_SIZE) size_reg = data;
    else if (idx == REG_UNIT_COUNT) count_reg = data[UCNT_W-1:0];
    @(posedge clk);
  endtask

  // unused command gives no result, so allow some slack after the last one
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic release_held(input logic [COUNT_W-1:0] cnt);
    int idx;
    logic [AW-1:0] addr;
    idx  = $urandom_range(0, held_units.size() - 1);
    addr = held_units[idx];
    held_units.delete(idx);
    send_item(CMD_FREE, cnt, addr);
  endtask

  task automatic test_not_ready();
    send_item(CMD_ALLOC, 7'd1, '0);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, '0, '0);
    send_item(CMD_FREE, '1, ADDR_TOP);
    send_item(CMD_UNUSED, '1, ADDR_TOP);
    wait_idle();
  endtask

  task automatic test_init_refusals();
    write_reg(REG_UNIT_SIZE, '0);
    send_item(CMD_INIT, '0, '0);
    wait_idle();
    write_reg(REG_UNIT_SIZE, '1);
    write_reg(REG_UNIT_COUNT, '0);
    send_item(CMD_INIT, '1, ADDR_TOP);
    wait_idle();
    write_reg(REG_UNIT_COUNT, '1);
    send_item(CMD_INIT, '0, '0);
    wait_idle();
    write_reg(REG_UNIT_COUNT, CFG_DATA_W'(DEF_MAX_UNITS + 1));
    send_item(CMD_INIT, '0, '0);
    wait_idle();
  endtask

  // largest unit size over the full unit count: the one init that succeeds
  task automatic test_init_pool();
    write_reg(REG_UNIT_COUNT, CFG_DATA_W'(DEF_MAX_UNITS));
    send_item(CMD_INIT, '0, '0);
    send_item(CMD_INIT, '0, '0);
    wait_idle();
  endtask

  task automatic test_free_checks();
    send_item(CMD_FREE, '0, '0);
    send_item(CMD_FREE, '0, AW'(pool_limit));
    send_item(CMD_FREE, '1, ADDR_TOP);
    wait_idle();
  endtask

  task automatic test_alloc_limits();
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_ALLOC, COUNT_W'(COUNT_TOP), '0);
    send_item(CMD_ALLOC, COUNT_W'(DEF_MAX_BATCH + 1), '0);
    send_item(CMD_ALLOC, COUNT_W'(DEF_MAX_BATCH), '0);
    send_item(CMD_ALLOC, 7'd1, ADDR_TOP);
    release_held('0);
    release_held('1);
    send_item(CMD_UNUSED, '0, '0);
    wait_idle();
  endtask

  task automatic random_item();
    int pick;
    int alloc_share;
    logic [COUNT_W-1:0] cnt;
    logic [AW-1:0] addr;
    cnt  = COUNT_W'($urandom);
    addr = AW'($urandom);
    pick = $urandom_range(0, 99);
    // drain hard while the list is well stocked, then hover near empty
    alloc_share = (units_free > 200) ? 76 : 46;
    if (pick < 6) begin
      case ($urandom_range(0, 4))
        0: send_item(CMD_UNUSED, cnt, addr);
        1: send_item(CMD_INIT, cnt, addr);
        2: send_item(CMD_ALLOC, '0, addr);
        3: send_item(CMD_ALLOC, COUNT_W'($urandom_range(DEF_MAX_BATCH + 1, COUNT_TOP)), addr);
        default: send_item(CMD_FREE, cnt, AW'($urandom_range(int'(pool_limit), int'(ADDR_TOP))));
      endcase
    end else if (pick < alloc_share) begin
      if ($urandom_range(0, 1)) cnt = COUNT_W'($urandom_range(1, 8));
      else cnt = COUNT_W'($urandom_range(1, DEF_MAX_BATCH));
      send_item(CMD_ALLOC, cnt, addr);
    end else if (held_units.size() != 0 && $urandom_range(0, 9) != 0) begin
      release_held(cnt);
    end else begin
      send_item(CMD_FREE, cnt, addr);
    end
  endtask

  task automatic test_random_traffic();
    repeat (PHASE_ITEMS) random_item();
    wait_idle();
  endtask

  // register writes after setup must leave the pool alone
  task automatic test_config_churn(input int phase);
    case (phase)
      0: begin
        write_reg(REG_UNIT_SIZE, '0);
        write_reg(REG_UNIT_COUNT, '0);
      end
      1: begin
        write_reg(REG_UNIT_SIZE, '1);
        write_reg(REG_UNIT_COUNT, '1);
      end
      2: begin
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
        write_reg(REG_UNIT_SIZE, CFG_DATA_W'($urandom));
      end
      default: begin
        write_reg(REG_UNIT_SIZE, USIZE_RESET);
        write_reg(REG_UNIT_COUNT, CFG_DATA_W'(UCNT_RESET));
      end
    endcase
    send_item(CMD_INIT, '0, '0);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: status %0d unit_address %0h last %0b free_units %0d",
                   out_status, out_unit_address, out_last, out_free_units);
      end else begin
        head_result = pending_results.pop_front();
        if (out_status !== head_result.status ||
            out_unit_address !== head_result.unit_address ||
            out_last !== head_result.last ||
            out_free_units !== head_result.free_units) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch (exp/act): status %0d/%0d unit_address %0h/%0h ",
                      "last %0b/%0b free_units %0d/%0d"},
                     head_result.status, out_status,
                     head_result.unit_address, out_unit_address,
                     head_result.last, out_last,
                     head_result.free_units, out_free_units);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[fixed_unit_pool_allocator_core] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_ready();
    test_init_refusals();
    test_init_pool();
    test_free_checks();
    test_alloc_limits();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_gap = (p % 2 == 1);
      test_random_traffic();
      test_config_churn(p);
    end
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[fixed_unit_pool_allocator_core] OK");
    end else begin
      $display("[fixed_unit_pool_allocator_core] ERROR");
    end
    $finish;
  end

endmodule
